// ----- design/bpec_pkg.sv -----
package bpec_pkg;

  localparam int unsigned NUM_BUTTONS = 11;

  // fixed field widths
  localparam int unsigned LEVEL_W    = 11;
  localparam int unsigned EVT_W      = 3;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned DEB_W      = 4;
  localparam int unsigned HCNT_W     = 10;
  localparam int unsigned CCNT_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // register reset values
  localparam logic [DEB_W-1:0]  DEB_RST   = DEB_W'(3);
  localparam logic [HCNT_W-1:0] LONG_RST  = HCNT_W'(100);
  localparam logic [HCNT_W-1:0] VLONG_RST = HCNT_W'(300);
  localparam logic [CCNT_W-1:0] DWIN_RST  = CCNT_W'(50);
  localparam logic [HCNT_W-1:0] COMBO_RST = HCNT_W'(300);

  // buttons with a combo role
  localparam int unsigned BTN_FN1   = 5;
  localparam int unsigned BTN_FN2   = 6;
  localparam int unsigned BTN_FN3   = 7;
  localparam int unsigned BTN_FN4   = 8;
  localparam int unsigned BTN_FLASH = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE,
    CFG_LONG_HOLD,
    CFG_VERY_LONG,
    CFG_DOUBLE_WIN,
    CFG_COMBO
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SHORT,
    PH_LONG,
    PH_VLONG,
    PH_COMBO
  } phase_e;

  typedef enum logic [EVT_W-1:0] {
    EV_SHORT,
    EV_DOUBLE,
    EV_LONG_HOLD,
    EV_LONG,
    EV_VLONG_HOLD,
    EV_VLONG,
    EV_COMBO
  } evt_e;

  typedef enum logic [1:0] {
    CMB_NONE,
    CMB_JOIN,
    CMB_DROP
  } combo_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_RD,
    ST_T_WR,
    ST_T_SHORT,
    ST_DEB,
    ST_D_SCAN,
    ST_C_RD,
    ST_C_WR,
    ST_B_RD,
    ST_B_WR,
    ST_DONE
  } seq_e;

  // per-button timer record
  typedef struct packed {
    phase_e              phase;
    logic [HCNT_W-1:0]   hcnt;
    logic                cpend;
    logic [CCNT_W-1:0]   ccnt;
  } rec_t;

  typedef struct packed {
    evt_e                code;
    logic [IDX_W-1:0]    btn;
    logic [IDX_W-1:0]    partner;
  } evt_t;

  typedef struct packed {
    logic push;
    logic flush;
    evt_t evt;
  } evt_req_t;

  typedef struct packed {
    logic step_ok;
    logic pend;
  } evt_sts_t;

endpackage

// ----- design/bpec_in_if.sv -----
interface bpec_in_if;
  import bpec_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [LEVEL_W-1:0] button_levels;

  modport source (output valid, action, button_levels, input ready);
  modport sink (input valid, action, button_levels, output ready);
endinterface

// ----- design/bpec_out_if.sv -----
interface bpec_out_if;
  import bpec_pkg::*;

  logic             valid;
  logic             ready;
  logic [EVT_W-1:0] event_code;
  logic [IDX_W-1:0] button_index;
  logic [IDX_W-1:0] partner_index;
  logic             last;

  modport source (output valid, event_code, button_index, partner_index, last, input ready);
  modport sink (input valid, event_code, button_index, partner_index, last, output ready);
endinterface

// ----- design/bpec_rec_mem.sv -----
module bpec_rec_mem #(
  parameter int unsigned Depth = bpec_pkg::NUM_BUTTONS,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [Aw-1:0]   addr_i,
  input  logic            we_i,
  input  bpec_pkg::rec_t  wdata_i,
  output bpec_pkg::rec_t  rdata_o
);
  import bpec_pkg::*;

  rec_t             mem_q [Depth];
  rec_t             rd_q;
  logic [Depth-1:0] vld_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rd_q <= mem_q[addr_i];
  end

  // entries never written read as the cleared record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[addr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// ----- design/bpec_evt_out.sv -----
module bpec_evt_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bpec_pkg::evt_req_t   req_i,
  output bpec_pkg::evt_sts_t   sts_o,
  bpec_out_if.source           out_o
);
  import bpec_pkg::*;

  evt_t pend_q;
  logic pend_vld_q;
  evt_t out_q;
  logic out_last_q;
  logic out_vld_q;
  logic out_free;
  logic load_out;

  // newest event waits in pend_q until the next one or the end of the item decides last
  assign out_free = !out_vld_q || out_o.ready;
  assign load_out = (req_i.push || req_i.flush) && pend_vld_q;

  assign sts_o.step_ok = !pend_vld_q || out_free;
  assign sts_o.pend    = pend_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (req_i.push) begin
        pend_vld_q <= 1'b1;
      end else if (req_i.flush) begin
        pend_vld_q <= 1'b0;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      pend_q <= req_i.evt;
    end
    if (load_out) begin
      out_q      <= pend_q;
      out_last_q <= req_i.flush;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.event_code    = out_q.code;
  assign out_o.button_index  = out_q.btn;
  assign out_o.partner_index = out_q.partner;
  assign out_o.last          = out_last_q;

endmodule

// ----- design/button_press_event_classifier_top.sv -----
// channel   dir  fields                                            transfer
// in_i      in   action, button_levels                              valid & ready
// out_o     out  event_code, button_index, partner_index, last      valid & ready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                    cfg_we_i, no wait
//
// a pin-change notice is taken in idle without leaving it; a tick walks the
// single-port timer memory with a read and a write state per button, plus one more
// state for a button giving two events; once the debounce count runs out a closing
// scan reads and writes each accepted button, after 0, 2 or 3 combo entries rewritten.
// reset clears control state and marks every timer record as cleared; no sweep needed.
// a stalled output holds the scan at its next event; in_i is ready only between items.
module button_press_event_classifier_top #(
  parameter int unsigned NumButtons = bpec_pkg::NUM_BUTTONS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bpec_in_if.sink                           in_i,
  bpec_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [bpec_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bpec_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import bpec_pkg::*;

  localparam int unsigned AW = $clog2(NumButtons);

  seq_e state_q, state_d;

  logic [DEB_W-1:0]  deb_ticks_q;
  logic [HCNT_W-1:0] long_q;
  logic [HCNT_W-1:0] vlong_q;
  logic [CCNT_W-1:0] dwin_q;
  logic [HCNT_W-1:0] combo_q;

  logic [NumButtons-1:0] lv_in;
  logic [NumButtons-1:0] lv_q;
  logic [NumButtons-1:0] stable_q;
  logic [NumButtons-1:0] first_q;
  logic [NumButtons-1:0] chg;
  logic [NumButtons-1:0] chg_q;
  logic [NumButtons-1:0] is_down_q;
  logic [DEB_W-1:0]      deb_q;
  logic                  track_q;
  logic [AW-1:0]         idx_q;
  logic [1:0]            cidx_q;

  logic [AW-1:0]         bidx_q;
  logic                  push_q;
  combo_e                kind_q;
  logic [AW-1:0]         partner_q;

  // memory port
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  rec_t          mem_wdata;
  rec_t          mem_rd;

  evt_req_t req;
  evt_sts_t sts;

  // tick step
  rec_t             tick_rec;
  logic             hold_ev_vld;
  evt_t             hold_ev;
  logic             short_vld;
  evt_t             short_ev;
  logic             tick_pvld;
  logic [IDX_W-1:0] tick_partner;
  logic             scan_last;
  logic             scan_adv;

  // debounce step
  logic [AW-1:0]         scan_b;
  logic                  scan_push;
  logic [NumButtons-1:0] scan_nd;
  combo_e                scan_kind;
  logic [AW-1:0]         scan_partner;
  logic [AW-1:0]         combo_addr;
  rec_t                  combo_rec;
  logic                  combo_last;
  rec_t                  btn_rec;
  logic                  btn_ev_vld;
  evt_t                  btn_ev;
  logic [HCNT_W-1:0]     hbase;

  logic in_xfer;

  function automatic logic [AW-1:0] low_idx(input logic [NumButtons-1:0] m);
    logic [AW-1:0] r;
    r = '0;
    for (int i = NumButtons - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = AW'(i);
      end
    end
    return r;
  endfunction

  // buttons beyond the level field read as released
  for (genvar gi = 0; gi < NumButtons; gi++) begin : g_lv
    if (gi < LEVEL_W) begin : g_pin
      assign lv_in[gi] = in_i.button_levels[gi];
    end else begin : g_pad
      assign lv_in[gi] = 1'b1;
    end
  end

  assign in_xfer = in_i.valid && in_i.ready;

  bpec_rec_mem #(
    .Depth (NumButtons)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .addr_i  (mem_addr),
    .we_i    (mem_we),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rd)
  );

  bpec_evt_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .sts_o  (sts),
    .out_o  (out_o)
  );

  // ---------------- tick step on one record ----------------
  always_comb begin
    if (is_down_q[BTN_FN1]) begin
      tick_pvld = 1'b1; tick_partner = IDX_W'(BTN_FN1);
    end else if (is_down_q[BTN_FN2]) begin
      tick_pvld = 1'b1; tick_partner = IDX_W'(BTN_FN2);
    end else if (is_down_q[BTN_FN3]) begin
      tick_pvld = 1'b1; tick_partner = IDX_W'(BTN_FN3);
    end else if (is_down_q[BTN_FN4]) begin
      tick_pvld = 1'b1; tick_partner = IDX_W'(BTN_FN4);
    end else begin
      tick_pvld = 1'b0; tick_partner = '0;
    end
  end

  always_comb begin
    tick_rec    = mem_rd;
    hold_ev_vld = 1'b0;
    hold_ev     = '0;
    short_vld   = 1'b0;
    short_ev    = '0;
    hold_ev.btn = IDX_W'(idx_q);
    short_ev.btn  = IDX_W'(idx_q);
    short_ev.code = EV_SHORT;
    if (mem_rd.hcnt != '0) begin
      tick_rec.hcnt = mem_rd.hcnt - HCNT_W'(1);
      if (mem_rd.hcnt == HCNT_W'(1)) begin
        case (mem_rd.phase)
          PH_SHORT: begin
            tick_rec.hcnt  = vlong_q;
            tick_rec.phase = PH_LONG;
            hold_ev_vld    = 1'b1;
            hold_ev.code   = EV_LONG_HOLD;
          end
          PH_LONG: begin
            tick_rec.phase = PH_VLONG;
            hold_ev_vld    = 1'b1;
            hold_ev.code   = EV_VLONG_HOLD;
          end
          PH_COMBO: begin
            tick_rec.phase  = PH_IDLE;
            hold_ev_vld     = tick_pvld;
            hold_ev.code    = EV_COMBO;
            hold_ev.partner = tick_partner;
          end
          default: ;
        endcase
      end
    end
    if (mem_rd.ccnt != '0) begin
      tick_rec.ccnt = mem_rd.ccnt - CCNT_W'(1);
      if (mem_rd.ccnt == CCNT_W'(1)) begin
        // double-click window ran out: single short press
        tick_rec.cpend = 1'b0;
        tick_rec.phase = PH_IDLE;
        short_vld      = 1'b1;
      end
    end
  end

  assign scan_last = (idx_q == AW'(NumButtons - 1));
  assign scan_adv  = sts.step_ok &&
                     ((state_q == ST_T_WR && !(hold_ev_vld && short_vld)) ||
                      state_q == ST_T_SHORT);

  // ---------------- debounce acceptance ----------------
  assign chg = (lv_q ^ stable_q) & ~(lv_q ^ first_q);

  always_comb begin
    scan_b    = low_idx(chg_q);
    scan_push = !lv_q[scan_b];
    scan_nd   = is_down_q;
    scan_nd[scan_b] = scan_push;
    if (scan_nd[BTN_FLASH] && (scan_nd[BTN_FN1] || scan_nd[BTN_FN4])) begin
      scan_kind = CMB_JOIN;
    end else if (track_q) begin
      scan_kind = CMB_DROP;
    end else begin
      scan_kind = CMB_NONE;
    end
    scan_partner = scan_nd[BTN_FN1] ? AW'(BTN_FN1) : AW'(BTN_FN4);
  end

  always_comb begin
    case (kind_q)
      CMB_JOIN: combo_addr = (cidx_q == 2'd0) ? partner_q : AW'(BTN_FLASH);
      CMB_DROP: begin
        case (cidx_q)
          2'd0:    combo_addr = AW'(BTN_FLASH);
          2'd1:    combo_addr = AW'(BTN_FN1);
          default: combo_addr = AW'(BTN_FN4);
        endcase
      end
      default: combo_addr = AW'(BTN_FLASH);
    endcase
    combo_last = (kind_q == CMB_JOIN && cidx_q == 2'd1) ||
                 (kind_q == CMB_DROP && cidx_q == 2'd2);
    combo_rec       = mem_rd;
    combo_rec.phase = PH_IDLE;
    combo_rec.hcnt  = '0;
    // flash timer doubles as the combo timer
    if (kind_q == CMB_JOIN && cidx_q == 2'd1) begin
      combo_rec.phase = PH_COMBO;
      combo_rec.hcnt  = combo_q;
    end
  end

  always_comb begin
    btn_rec    = mem_rd;
    btn_ev_vld = 1'b0;
    btn_ev     = '0;
    btn_ev.btn = IDX_W'(bidx_q);
    hbase = (kind_q == CMB_JOIN && bidx_q == AW'(BTN_FLASH)) ? mem_rd.hcnt : '0;
    btn_rec.hcnt = hbase;
    if (push_q) begin
      if (!track_q) begin
        btn_rec.phase = PH_SHORT;
        btn_rec.hcnt  = long_q;
      end
    end else begin
      btn_rec.phase = PH_IDLE;
      case (mem_rd.phase)
        PH_SHORT: begin
          if (!mem_rd.cpend) begin
            btn_rec.cpend = 1'b1;
            btn_rec.ccnt  = dwin_q;
          end else begin
            btn_rec.cpend = 1'b0;
            btn_rec.ccnt  = '0;
            btn_ev_vld    = 1'b1;
            btn_ev.code   = EV_DOUBLE;
          end
        end
        PH_LONG: begin
          btn_ev_vld  = 1'b1;
          btn_ev.code = EV_LONG;
        end
        PH_VLONG: begin
          btn_ev_vld  = 1'b1;
          btn_ev.code = EV_VLONG;
        end
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid && !in_i.action) begin
          state_d = ST_T_RD;
        end
      end
      ST_T_RD: state_d = ST_T_WR;
      ST_T_WR: begin
        if (sts.step_ok) begin
          if (hold_ev_vld && short_vld) begin
            state_d = ST_T_SHORT;
          end else if (scan_last) begin
            state_d = ST_DEB;
          end else begin
            state_d = ST_T_RD;
          end
        end
      end
      ST_T_SHORT: begin
        if (sts.step_ok) begin
          state_d = scan_last ? ST_DEB : ST_T_RD;
        end
      end
      ST_DEB: state_d = (deb_q == DEB_W'(1)) ? ST_D_SCAN : ST_DONE;
      ST_D_SCAN: begin
        if (chg_q == '0) begin
          state_d = ST_DONE;
        end else if (scan_kind == CMB_NONE) begin
          state_d = ST_B_RD;
        end else begin
          state_d = ST_C_RD;
        end
      end
      ST_C_RD: state_d = ST_C_WR;
      ST_C_WR: state_d = combo_last ? ST_B_RD : ST_C_RD;
      ST_B_RD: state_d = ST_B_WR;
      ST_B_WR: begin
        if (sts.step_ok) begin
          state_d = ST_D_SCAN;
        end
      end
      ST_DONE: begin
        if (sts.step_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    mem_addr   = idx_q;
    mem_we     = 1'b0;
    mem_wdata  = tick_rec;
    req        = '0;
    unique case (state_q)
      ST_T_RD: mem_addr = idx_q;
      ST_T_WR: begin
        mem_addr  = idx_q;
        mem_we    = sts.step_ok;
        mem_wdata = tick_rec;
        req.push  = sts.step_ok && (hold_ev_vld || short_vld);
        req.evt   = hold_ev_vld ? hold_ev : short_ev;
      end
      ST_T_SHORT: begin
        req.push = sts.step_ok;
        req.evt  = short_ev;
      end
      ST_C_RD: mem_addr = combo_addr;
      ST_C_WR: begin
        mem_addr  = combo_addr;
        mem_we    = 1'b1;
        mem_wdata = combo_rec;
      end
      ST_B_RD: mem_addr = bidx_q;
      ST_B_WR: begin
        mem_addr  = bidx_q;
        mem_we    = sts.step_ok;
        mem_wdata = btn_rec;
        req.push  = sts.step_ok && btn_ev_vld;
        req.evt   = btn_ev;
      end
      ST_DONE: req.flush = sts.step_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration; zero counts as one, so store the effective value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q <= DEB_RST;
      long_q      <= LONG_RST;
      vlong_q     <= VLONG_RST;
      dwin_q      <= DWIN_RST;
      combo_q     <= COMBO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE: begin
          deb_ticks_q <= (cfg_data_i[DEB_W-1:0] == '0) ? DEB_W'(1) : cfg_data_i[DEB_W-1:0];
        end
        CFG_LONG_HOLD: begin
          long_q <= (cfg_data_i[HCNT_W-1:0] == '0) ? HCNT_W'(1) : cfg_data_i[HCNT_W-1:0];
        end
        CFG_VERY_LONG: begin
          vlong_q <= (cfg_data_i[HCNT_W-1:0] == '0) ? HCNT_W'(1) : cfg_data_i[HCNT_W-1:0];
        end
        CFG_DOUBLE_WIN: begin
          dwin_q <= (cfg_data_i[CCNT_W-1:0] == '0) ? CCNT_W'(1) : cfg_data_i[CCNT_W-1:0];
        end
        CFG_COMBO: begin
          combo_q <= (cfg_data_i[HCNT_W-1:0] == '0) ? HCNT_W'(1) : cfg_data_i[HCNT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= '1;
      first_q   <= '1;
      deb_q     <= '0;
      chg_q     <= '0;
      is_down_q <= '0;
      track_q   <= 1'b0;
      idx_q     <= '0;
      cidx_q    <= '0;
    end else begin
      if (in_xfer) begin
        if (in_i.action) begin
          first_q <= lv_in;
          deb_q   <= deb_ticks_q;
        end else begin
          idx_q <= '0;
        end
      end
      if (scan_adv) begin
        idx_q <= idx_q + AW'(1);
      end
      if (state_q == ST_DEB && deb_q != '0) begin
        deb_q <= deb_q - DEB_W'(1);
        if (deb_q == DEB_W'(1)) begin
          stable_q <= lv_q;
          chg_q    <= chg;
        end
      end
      if (state_q == ST_D_SCAN && chg_q != '0) begin
        chg_q[scan_b] <= 1'b0;
        is_down_q     <= scan_nd;
        cidx_q        <= '0;
        if (scan_kind == CMB_JOIN) begin
          track_q <= 1'b1;
        end else if (scan_kind == CMB_DROP) begin
          track_q <= 1'b0;
        end
      end
      if (state_q == ST_C_WR) begin
        cidx_q <= cidx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && !in_i.action) begin
      lv_q <= lv_in;
    end
    if (state_q == ST_D_SCAN && chg_q != '0) begin
      bidx_q    <= scan_b;
      push_q    <= scan_push;
      kind_q    <= scan_kind;
      partner_q <= scan_partner;
    end
  end

  // ---------------- checks ----------------
  a_track_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    track_q |-> is_down_q[BTN_FLASH] && (is_down_q[BTN_FN1] || is_down_q[BTN_FN4]))
    else $error("combo tracking without flash and partner held");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_T_RD) |-> (idx_q <= AW'(NumButtons - 1)))
    else $error("timer scan index out of range");

  a_combo_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_C_WR) |-> (mem_addr == AW'(BTN_FLASH) || mem_addr == AW'(BTN_FN1) ||
                              mem_addr == AW'(BTN_FN4)))
    else $error("combo update hit a non-combo button");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && sts.step_ok) |=> !sts.pend)
    else $error("event left pending after item end");

endmodule

// ----- tb/tb_button_press_event_classifier_top.sv -----
module tb_button_press_event_classifier_top;
  import bpec_pkg::*;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_NOTICE = 1'b1;

  // directed rows either must stay silent or are checked against the predictor
  localparam logic ROW_QUIET = 1'b1;
  localparam logic ROW_PRED  = 1'b0;

  localparam int unsigned SETTLE_CYCLES   = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned NUM_ROWS        = 27;

  typedef struct packed {
    logic               act;
    logic [LEVEL_W-1:0] lv;
    logic               quiet;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    '{ACT_TICK,   11'h7FF, ROW_QUIET},  // nothing pending after reset
    '{ACT_NOTICE, 11'h000, ROW_QUIET},
    '{ACT_TICK,   11'h000, ROW_PRED},   // every button pushed at once
    '{ACT_TICK,   11'h000, ROW_PRED},
    '{ACT_NOTICE, 11'h7FF, ROW_QUIET},
    '{ACT_TICK,   11'h7FF, ROW_PRED},   // every button released
    '{ACT_NOTICE, 11'h7FE, ROW_QUIET},
    '{ACT_TICK,   11'h7FE, ROW_PRED},
    '{ACT_NOTICE, 11'h7FF, ROW_QUIET},
    '{ACT_TICK,   11'h7FF, ROW_PRED},
    '{ACT_NOTICE, 11'h7FE, ROW_QUIET},
    '{ACT_TICK,   11'h7FE, ROW_PRED},
    '{ACT_NOTICE, 11'h7FF, ROW_QUIET},
    '{ACT_TICK,   11'h7FF, ROW_PRED},   // second click released as the window runs out: short press, no double
    '{ACT_NOTICE, 11'h7FD, ROW_QUIET},
    '{ACT_TICK,   11'h7FD, ROW_PRED},
    '{ACT_TICK,   11'h7FD, ROW_PRED},
    '{ACT_TICK,   11'h7FD, ROW_PRED},
    '{ACT_TICK,   11'h7FD, ROW_PRED},
    '{ACT_NOTICE, 11'h7FF, ROW_QUIET},
    '{ACT_TICK,   11'h7FF, ROW_PRED},   // very long release
    '{ACT_NOTICE, 11'h4FF, ROW_QUIET},  // flash with fn4
    '{ACT_TICK,   11'h4FF, ROW_PRED},
    '{ACT_TICK,   11'h4FF, ROW_PRED},
    '{ACT_TICK,   11'h4FF, ROW_PRED},
    '{ACT_NOTICE, 11'h5A5, ROW_QUIET},
    '{ACT_TICK,   11'h7FF, ROW_PRED}    // levels disagree with the capture
  };

  typedef struct {
    evt_e             code;
    logic [IDX_W-1:0] btn;
    logic [IDX_W-1:0] partner;
    logic             last;
  } press_evt_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bpec_in_if  in_bus ();
  bpec_out_if out_bus ();

  button_press_event_classifier_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of the timing registers
  logic [DEB_W-1:0]  cfg_settle;
  logic [HCNT_W-1:0] cfg_long;
  logic [HCNT_W-1:0] cfg_vlong;
  logic [CCNT_W-1:0] cfg_dwin;
  logic [HCNT_W-1:0] cfg_combo;

  // predictor copy of the button state
  logic [LEVEL_W-1:0] lv_stable;
  logic [LEVEL_W-1:0] lv_capture;
  logic [DEB_W-1:0]   settle_left;
  phase_e             btn_phase   [NUM_BUTTONS];
  logic [HCNT_W-1:0]  hold_left   [NUM_BUTTONS];
  logic               click_armed [NUM_BUTTONS];
  logic [CCNT_W-1:0]  click_left  [NUM_BUTTONS];
  logic               btn_down    [NUM_BUTTONS];
  logic               combo_armed;

  evt_t       step_evts [$];
  press_evt_t pending_events [$];

  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned items_sent;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          hold_req;
  logic [LEVEL_W-1:0] held_lv;
  int          last_flip;

  function automatic logic [HCNT_W-1:0] floor_one(logic [HCNT_W-1:0] v);
    return (v == '0) ? HCNT_W'(1) : v;
  endfunction

  function automatic void clear_press_state();
    cfg_settle  = DEB_RST;
    cfg_long    = LONG_RST;
    cfg_vlong   = VLONG_RST;
    cfg_dwin    = DWIN_RST;
    cfg_combo   = COMBO_RST;
    lv_stable   = '1;
    lv_capture  = '1;
    settle_left = '0;
    combo_armed = 1'b0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      btn_phase[b]   = PH_IDLE;
      hold_left[b]   = '0;
      click_armed[b] = 1'b0;
      click_left[b]  = '0;
      btn_down[b]    = 1'b0;
    end
  endfunction

  function automatic void note_event(evt_e code, int btn, int partner);
    evt_t e;
    e.code    = code;
    e.btn     = IDX_W'(btn);
    e.partner = IDX_W'(partner);
    step_evts.push_back(e);
  endfunction

  // flash held with fn1 (else fn4) turns the flash hold timer into the combo timer
  function automatic void apply_combo_rule();
    int partner;
    partner = -1;
    if (btn_down[BTN_FLASH] && btn_down[BTN_FN1]) partner = BTN_FN1;
    else if (btn_down[BTN_FLASH] && btn_down[BTN_FN4]) partner = BTN_FN4;
    if (partner >= 0) begin
      hold_left[partner]   = '0;
      btn_phase[partner]   = PH_IDLE;
      btn_phase[BTN_FLASH] = PH_COMBO;
      hold_left[BTN_FLASH] = floor_one(cfg_combo);
      combo_armed          = 1'b1;
    end else if (combo_armed) begin
      btn_phase[BTN_FLASH] = PH_IDLE;
      btn_phase[BTN_FN1]   = PH_IDLE;
      btn_phase[BTN_FN4]   = PH_IDLE;
      hold_left[BTN_FLASH] = '0;
      hold_left[BTN_FN1]   = '0;
      hold_left[BTN_FN4]   = '0;
      combo_armed          = 1'b0;
    end
  endfunction

  function automatic void press_button(int b);
    btn_down[b] = 1'b1;
    apply_combo_rule();
    if (!combo_armed) begin
      btn_phase[b] = PH_SHORT;
      hold_left[b] = floor_one(cfg_long);
    end
  endfunction

  function automatic void release_button(int b);
    btn_down[b] = 1'b0;
    apply_combo_rule();
    case (btn_phase[b])
      PH_SHORT: begin
        if (!click_armed[b]) begin
          click_armed[b] = 1'b1;
          click_left[b]  = (cfg_dwin == '0) ? CCNT_W'(1) : cfg_dwin;
        end else begin
          click_armed[b] = 1'b0;
          click_left[b]  = '0;
          note_event(EV_DOUBLE, b, 0);
        end
      end
      PH_LONG:  note_event(EV_LONG, b, 0);
      PH_VLONG: note_event(EV_VLONG, b, 0);
      default: ;
    endcase
    btn_phase[b] = PH_IDLE;
  endfunction

  function automatic void hold_fired(int b);
    int partner;
    partner = -1;
    case (btn_phase[b])
      PH_SHORT: begin
        hold_left[b] = floor_one(cfg_vlong);
        btn_phase[b] = PH_LONG;
        note_event(EV_LONG_HOLD, b, 0);
      end
      PH_LONG: begin
        btn_phase[b] = PH_VLONG;
        note_event(EV_VLONG_HOLD, b, 0);
      end
      PH_COMBO: begin
        btn_phase[b] = PH_IDLE;
        if (btn_down[BTN_FN1]) partner = BTN_FN1;
        else if (btn_down[BTN_FN2]) partner = BTN_FN2;
        else if (btn_down[BTN_FN3]) partner = BTN_FN3;
        else if (btn_down[BTN_FN4]) partner = BTN_FN4;
        if (partner >= 0) note_event(EV_COMBO, b, partner);
      end
      default: ;
    endcase
  endfunction

  function automatic void accept_levels(logic [LEVEL_W-1:0] lv);
    logic [LEVEL_W-1:0] agree;
    logic [LEVEL_W-1:0] moved;
    agree     = ~(lv ^ lv_capture);
    moved     = (lv ^ lv_stable) & agree;
    lv_stable = lv;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (moved[b]) begin
        hold_left[b] = '0;
        if (!lv[b]) press_button(b);
        else release_button(b);
      end
    end
  endfunction

  function automatic void classify_item(logic act, logic [LEVEL_W-1:0] lv);
    step_evts.delete();
    if (act == ACT_NOTICE) begin
      lv_capture  = lv;
      settle_left = (cfg_settle == '0) ? DEB_W'(1) : cfg_settle;
    end else begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if (hold_left[b] != '0) begin
          hold_left[b] = hold_left[b] - 1'b1;
          if (hold_left[b] == '0) hold_fired(b);
        end
        if (click_left[b] != '0) begin
          click_left[b] = click_left[b] - 1'b1;
          if (click_left[b] == '0) begin
            click_armed[b] = 1'b0;
            btn_phase[b]   = PH_IDLE;
            note_event(EV_SHORT, b, 0);
          end
        end
      end
      if (settle_left != '0) begin
        settle_left = settle_left - 1'b1;
        if (settle_left == '0) accept_levels(lv);
      end
    end
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_DEBOUNCE:   cfg_settle = val[DEB_W-1:0];
      CFG_LONG_HOLD:  cfg_long   = val[HCNT_W-1:0];
      CFG_VERY_LONG:  cfg_vlong  = val[HCNT_W-1:0];
      CFG_DOUBLE_WIN: cfg_dwin   = val[CCNT_W-1:0];
      CFG_COMBO:      cfg_combo  = val[HCNT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_timing(input int deb, input int lng, input int vlg, input int dwin,
                            input int cmb);
    write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
    write_reg(CFG_LONG_HOLD, CFG_DATA_W'(lng));
    write_reg(CFG_VERY_LONG, CFG_DATA_W'(vlg));
    write_reg(CFG_DOUBLE_WIN, CFG_DATA_W'(dwin));
    write_reg(CFG_COMBO, CFG_DATA_W'(cmb));
    cfg_we_i <= 1'b0;
  endtask

  // called at a rising edge, returns at the edge of the transfer
  task automatic send_item(input logic act, input logic [LEVEL_W-1:0] lv,
                           input logic quiet);
    press_evt_t pe;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid         <= 1'b1;
    in_bus.action        <= act;
    in_bus.button_levels <= lv;
    do @(negedge clk_i); while (!in_bus.ready);
    classify_item(act, lv);
    if (!quiet) begin
      foreach (step_evts[k]) begin
        pe.code    = step_evts[k].code;
        pe.btn     = step_evts[k].btn;
        pe.partner = step_evts[k].partner;
        pe.last    = (k == step_evts.size() - 1);
        pending_events.push_back(pe);
      end
    end
    items_sent++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    // a trailing tick may still be walking the timers
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one settled level change, with bounces, broken captures and loose ticks mixed in
  task automatic run_gesture();
    int r;
    int b;
    int settle;
    logic [LEVEL_W-1:0] lv;
    r = $urandom_range(0, 9);
    if (r <= 4) begin
      if ($urandom_range(0, 1) == 0) b = last_flip;
      else b = $urandom_range(0, NUM_BUTTONS - 1);
      last_flip  = b;
      held_lv[b] = ~held_lv[b];
      if ($urandom_range(0, 3) == 0) begin
        b = $urandom_range(0, NUM_BUTTONS - 1);
        held_lv[b] = ~held_lv[b];
      end
    end else if (r == 5) begin
      held_lv = '1;
      held_lv[BTN_FLASH] = 1'b0;
      if ($urandom_range(0, 1) == 0) held_lv[BTN_FN1] = 1'b0;
      else held_lv[BTN_FN4] = 1'b0;
      if ($urandom_range(0, 1) == 0) held_lv[BTN_FN2] = 1'b0;
      if ($urandom_range(0, 2) == 0) held_lv[BTN_FN3] = 1'b0;
    end else if (r == 6) begin
      held_lv = '1;
    end else begin
      held_lv = LEVEL_W'($urandom_range(0, 2047));
    end
    lv     = held_lv;
    settle = (cfg_settle == '0) ? 1 : int'(cfg_settle);
    if (r == 8) send_item(ACT_NOTICE, LEVEL_W'($urandom_range(0, 2047)), 1'b0);
    send_item(ACT_NOTICE, lv, 1'b0);
    for (int k = 0; k < settle; k++) begin
      if (r == 9 && k == settle - 1)
        send_item(ACT_TICK, lv ^ LEVEL_W'($urandom_range(1, 2047)), 1'b0);
      else
        send_item(ACT_TICK, lv, 1'b0);
    end
    repeat ($urandom_range(0, 4))
      send_item(ACT_TICK, LEVEL_W'($urandom_range(0, 2047)), 1'b0);
    if ($urandom_range(0, 7) == 0)
      send_item(1'($urandom_range(0, 1)), LEVEL_W'($urandom_range(0, 2047)), 1'b0);
  endtask

  task automatic run_phase(input int unsigned src, input int unsigned snk,
                           input int unsigned target, input bit squeeze);
    src_idle_pct = src;
    snk_idle_pct = snk;
    items_sent   = 0;
    if (squeeze) hold_req = 1'b1;
    while (items_sent < target) run_gesture();
    drain();
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // result check and watchdog, sampled away from the driving edge
  initial begin
    press_evt_t pe;
    forever begin
      @(negedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        if (pending_events.size() == 0) begin
          $error("unexpected event: code %0d button %0d partner %0d last %0d",
                 out_bus.event_code, out_bus.button_index, out_bus.partner_index,
                 out_bus.last);
          mismatches++;
        end else begin
          pe = pending_events.pop_front();
          if (out_bus.event_code !== pe.code) begin
            $error("event_code: expected %0d, got %0d", pe.code, out_bus.event_code);
            mismatches++;
          end
          if (out_bus.button_index !== pe.btn) begin
            $error("button_index: expected %0d, got %0d", pe.btn, out_bus.button_index);
            mismatches++;
          end
          if (out_bus.partner_index !== pe.partner) begin
            $error("partner_index: expected %0d, got %0d", pe.partner,
                   out_bus.partner_index);
            mismatches++;
          end
          if (out_bus.last !== pe.last) begin
            $error("last: expected %0d, got %0d", pe.last, out_bus.last);
            mismatches++;
          end
        end
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_data_i           = '0;
    in_bus.valid         = 1'b0;
    in_bus.action        = ACT_TICK;
    in_bus.button_levels = '1;
    out_bus.ready        = 1'b0;
    mismatches           = 0;
    quiet_cycles         = 0;
    items_sent           = 0;
    hold_req             = 1'b0;
    held_lv              = '1;
    last_flip            = 0;
    src_idle_pct         = 15;
    snk_idle_pct         = 83;
    clear_press_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_timing(1, 2, 2, 2, 2);
    for (int i = 0; i < NUM_ROWS; i++)
      send_item(DIR_ROWS[i].act, DIR_ROWS[i].lv, DIR_ROWS[i].quiet);
    drain();

    set_timing($urandom_range(1, 3), $urandom_range(1, 6), $urandom_range(1, 6),
               $urandom_range(1, 4), $urandom_range(1, 6));
    run_phase(15, 83, 70, 1'b0);

    // zero counts as one in every register
    set_timing(0, 0, 0, 0, 0);
    run_phase(83, 15, 50, 1'b0);

    set_timing(15, 1023, 1023, 255, 1023);
    run_phase(83, 15, 30, 1'b0);

    set_timing($urandom_range(1, 4), $urandom_range(1, 10), $urandom_range(1, 10),
               $urandom_range(1, 8), $urandom_range(1, 10));
    run_phase(0, 0, 70, 1'b1);

    if (mismatches == 0 && pending_events.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
